/* design/trz_pkg.sv */
// ----------------------------------------------------------------------------
// trz_pkg
// Shared types and constants for the translate / rotate-about-z point pipeline.
// ----------------------------------------------------------------------------
package trz_pkg;

	// Coordinate width (signed Q16.16) and angle width
	localparam int CoordW = 32;
	localparam int AngleW = 16;

	// CORDIC datapath: x/y in Q2.30 with guard bits, z in 32-bit binary angle
	localparam int CordicW = 34;
	localparam int PhaseW  = 32;
	localparam int UnitW   = 32;
	localparam int ProdW   = 64;

	localparam int CordicStagesDefault = 16;
	localparam int AtanEntries         = 30;

	// 1/K in Q2.30
	localparam logic signed [CordicW-1:0] InvGainQ30 = 34'sh026DD3B6A;
	localparam logic signed [CordicW-1:0] OneQ30     = 34'sh040000000;

	// arctan(2^-i) in 32-bit binary angle units
	localparam logic signed [PhaseW-1:0] AtanTable [AtanEntries] = '{
		32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
		32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
		32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
		32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
		32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051, 32'sh00000029,
		32'sh00000014, 32'sh0000000A, 32'sh00000005, 32'sh00000003, 32'sh00000001
	};

	// Quadrant codes from the top two angle bits
	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quad_t;

	// Request payload that rides alongside the CORDIC pipeline
	typedef struct packed {
		logic signed [CoordW-1:0] dx;
		logic signed [CoordW-1:0] dy;
		logic signed [CoordW-1:0] dz;
		logic                     sat;
		quad_t                    quad;
	} side_t;

endpackage

/* design/trz_diff.sv */
// ----------------------------------------------------------------------------
// trz_diff
// Input stage: saturated point differences and CORDIC phase setup.
// ----------------------------------------------------------------------------
module trz_diff (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic signed [trz_pkg::CoordW-1:0]    test_x,
	input  logic signed [trz_pkg::CoordW-1:0]    test_y,
	input  logic signed [trz_pkg::CoordW-1:0]    test_z,
	input  logic signed [trz_pkg::CoordW-1:0]    origin_x,
	input  logic signed [trz_pkg::CoordW-1:0]    origin_y,
	input  logic signed [trz_pkg::CoordW-1:0]    origin_z,
	input  logic        [trz_pkg::AngleW-1:0]    angle,
	output logic                                 valid_s1,
	output trz_pkg::side_t                       side_s1,
	output logic signed [trz_pkg::PhaseW-1:0]    phase_s1
);
	import trz_pkg::*;

	logic signed [CoordW-1:0] dx, dy, dz;
	logic                     ox, oy, oz;

	// Subtract with one guard bit and clip to 32 bits
	function automatic logic signed [CoordW:0] sub_sat(input logic signed [CoordW-1:0] a,
		input logic signed [CoordW-1:0] b);
		logic signed [CoordW:0] d;
		logic                   ovf;
		d   = {a[CoordW-1], a} - {b[CoordW-1], b};
		ovf = d[CoordW] ^ d[CoordW-1];
		if (ovf) begin
			return {1'b1, d[CoordW], {(CoordW-1){~d[CoordW]}}};
		end
		return {1'b0, d[CoordW-1:0]};
	endfunction

	always_comb begin
		{ox, dx} = sub_sat(test_x, origin_x);
		{oy, dy} = sub_sat(test_y, origin_y);
		{oz, dz} = sub_sat(test_z, origin_z);
	end

	// Advance valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	// Register differences; residual angle below one quadrant goes to z
	always_ff @(posedge clk) begin
		side_s1.dx   <= dx;
		side_s1.dy   <= dy;
		side_s1.dz   <= dz;
		side_s1.sat  <= ox | oy | oz;
		side_s1.quad <= quad_t'(angle[AngleW-1 -: 2]);
		phase_s1     <= {2'b00, angle[AngleW-3:0], {(PhaseW-AngleW){1'b0}}};
	end

endmodule

/* design/trz_cordic.sv */
// ----------------------------------------------------------------------------
// trz_cordic
// Rotation-mode CORDIC, one registered micro-rotation per stage.
// ----------------------------------------------------------------------------
module trz_cordic #(
	parameter int CORDIC_STAGES = trz_pkg::CordicStagesDefault
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  trz_pkg::side_t                        side_in,
	input  logic signed [trz_pkg::PhaseW-1:0]     phase_in,
	output logic                                  out_valid,
	output trz_pkg::side_t                        side_out,
	output logic signed [trz_pkg::CordicW-1:0]    cos_raw,
	output logic signed [trz_pkg::CordicW-1:0]    sin_raw
);
	import trz_pkg::*;

	logic                      v_s    [CORDIC_STAGES+1];
	side_t                     side_s [CORDIC_STAGES+1];
	logic signed [CordicW-1:0] x_s    [CORDIC_STAGES+1];
	logic signed [CordicW-1:0] y_s    [CORDIC_STAGES+1];
	logic signed [PhaseW-1:0]  z_s    [CORDIC_STAGES+1];

	// Seed the rotation with 1/K on x
	always_comb begin
		v_s[0]    = in_valid;
		side_s[0] = side_in;
		x_s[0]    = InvGainQ30;
		y_s[0]    = '0;
		z_s[0]    = phase_in;
	end

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
		// Advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		// Rotate toward zero residual angle
		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (!z_s[i][PhaseW-1]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] - AtanTable[i];
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
				z_s[i+1] <= z_s[i] + AtanTable[i];
			end
		end
	end

	assign out_valid = v_s[CORDIC_STAGES];
	assign side_out  = side_s[CORDIC_STAGES];
	assign cos_raw   = x_s[CORDIC_STAGES];
	assign sin_raw   = y_s[CORDIC_STAGES];

	// A valid output always traces back to a valid input that passed through every stage
	a_valid_latency: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $past(in_valid, CORDIC_STAGES))
		else $error("cordic valid latency mismatch");

endmodule

/* design/trz_rotate.sv */
// ----------------------------------------------------------------------------
// trz_rotate
// Quadrant fold, products with the rotation matrix, round and saturate.
// ----------------------------------------------------------------------------
module trz_rotate (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  trz_pkg::side_t                        side_in,
	input  logic signed [trz_pkg::CordicW-1:0]    cos_raw,
	input  logic signed [trz_pkg::CordicW-1:0]    sin_raw,
	output logic                                  out_valid,
	output logic signed [trz_pkg::CoordW-1:0]     local_x,
	output logic signed [trz_pkg::CoordW-1:0]     local_y,
	output logic signed [trz_pkg::CoordW-1:0]     local_z,
	output logic                                  saturated
);
	import trz_pkg::*;

	localparam logic signed [ProdW-1:0] RoundHalf = 64'sd536870912;
	localparam logic signed [ProdW-1:0] MaxCoord  = 64'sd2147483647;
	localparam logic signed [ProdW-1:0] MinCoord  = -64'sd2147483648;

	logic signed [CordicW-1:0] c_fold, s_fold;
	logic signed [UnitW-1:0]   c_s1, s_s1;
	side_t                     side_s1, side_s2;
	logic                      v_s1, v_s2;
	logic signed [ProdW-1:0]   xc_s2, ys_s2, yc_s2, xs_s2;
	logic signed [ProdW-1:0]   sum_x, sum_y, sh_x, sh_y;
	logic signed [CoordW-1:0]  lx, ly;
	logic                      ovx, ovy;

	function automatic logic signed [UnitW-1:0] clamp_unit(input logic signed [CordicW-1:0] v);
		if (v > OneQ30) begin
			return OneQ30[UnitW-1:0];
		end
		if (v < -OneQ30) begin
			return UnitW'(-OneQ30);
		end
		return v[UnitW-1:0];
	endfunction

	// Fold the first-quadrant result into the full circle
	always_comb begin
		unique case (side_in.quad)
			QUAD_1: begin
				c_fold = -sin_raw;
				s_fold = cos_raw;
			end
			QUAD_2: begin
				c_fold = -cos_raw;
				s_fold = -sin_raw;
			end
			QUAD_3: begin
				c_fold = sin_raw;
				s_fold = -cos_raw;
			end
			default: begin
				c_fold = cos_raw;
				s_fold = sin_raw;
			end
		endcase
	end

	// Round half up, then clip each rotated sum to 32 bits
	always_comb begin
		sum_x = xc_s2 + ys_s2 + RoundHalf;
		sum_y = yc_s2 - xs_s2 + RoundHalf;
		sh_x  = sum_x >>> 30;
		sh_y  = sum_y >>> 30;
		ovx   = (sh_x > MaxCoord) || (sh_x < MinCoord);
		ovy   = (sh_y > MaxCoord) || (sh_y < MinCoord);
		lx    = ovx ? (sh_x[ProdW-1] ? MinCoord[CoordW-1:0] : MaxCoord[CoordW-1:0])
			: sh_x[CoordW-1:0];
		ly    = ovy ? (sh_y[ProdW-1] ? MinCoord[CoordW-1:0] : MaxCoord[CoordW-1:0])
			: sh_y[CoordW-1:0];
	end

	// Advance valid through fold, multiply and sum stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			out_valid <= v_s2;
		end
	end

	// Hold the datapath registers
	always_ff @(posedge clk) begin
		c_s1      <= clamp_unit(c_fold);
		s_s1      <= clamp_unit(s_fold);
		side_s1   <= side_in;
		xc_s2     <= ProdW'(side_s1.dx) * ProdW'(c_s1);
		ys_s2     <= ProdW'(side_s1.dy) * ProdW'(s_s1);
		yc_s2     <= ProdW'(side_s1.dy) * ProdW'(c_s1);
		xs_s2     <= ProdW'(side_s1.dx) * ProdW'(s_s1);
		side_s2   <= side_s1;
		local_x   <= lx;
		local_y   <= ly;
		local_z   <= side_s2.dz;
		saturated <= side_s2.sat | ovx | ovy;
	end

	// Folded sine and cosine stay inside the unit range
	a_unit_cos: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (c_s1 <= UnitW'(OneQ30)) && (c_s1 >= UnitW'(-OneQ30)))
		else $error("cosine out of unit range");

	a_unit_sin: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (s_s1 <= UnitW'(OneQ30)) && (s_s1 >= UnitW'(-OneQ30)))
		else $error("sine out of unit range");

	// A clipped difference always shows up in the saturation flag
	a_sat_carry: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && side_s2.sat) |=> (out_valid && saturated))
		else $error("difference saturation lost");

endmodule

/* design/translate_rotate_point_z_top.sv */
// ----------------------------------------------------------------------------
// translate_rotate_point_z_top
// Each accepted request yields a done strobe once it has passed every pipeline register.
// Throughput: one request per cycle; busy stays low, the pipeline never stalls.
// Depth is set by one register per CORDIC micro-rotation plus diff, fold,
// multiply and round/saturate stages.
// Reset clears all valid bits; requests in flight are dropped.
// ----------------------------------------------------------------------------
module translate_rotate_point_z_top #(
	parameter int CORDIC_STAGES = trz_pkg::CordicStagesDefault
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [trz_pkg::CoordW-1:0]    test_x,
	input  logic signed [trz_pkg::CoordW-1:0]    test_y,
	input  logic signed [trz_pkg::CoordW-1:0]    test_z,
	input  logic signed [trz_pkg::CoordW-1:0]    origin_x,
	input  logic signed [trz_pkg::CoordW-1:0]    origin_y,
	input  logic signed [trz_pkg::CoordW-1:0]    origin_z,
	input  logic        [trz_pkg::AngleW-1:0]    angle,
	output logic                                 done,
	output logic signed [trz_pkg::CoordW-1:0]    local_x,
	output logic signed [trz_pkg::CoordW-1:0]    local_y,
	output logic signed [trz_pkg::CoordW-1:0]    local_z,
	output logic                                 saturated
);
	import trz_pkg::*;

	localparam int Latency = CORDIC_STAGES + 4;

	logic                      accept;
	logic                      v_s1, v_cd;
	side_t                     side_s1, side_cd;
	logic signed [PhaseW-1:0]  phase_s1;
	logic signed [CordicW-1:0] cos_raw, sin_raw;

	// Take a request whenever start is high
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	trz_diff u_diff (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.test_x   (test_x),
		.test_y   (test_y),
		.test_z   (test_z),
		.origin_x (origin_x),
		.origin_y (origin_y),
		.origin_z (origin_z),
		.angle    (angle),
		.valid_s1 (v_s1),
		.side_s1  (side_s1),
		.phase_s1 (phase_s1)
	);

	trz_cordic #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.side_in   (side_s1),
		.phase_in  (phase_s1),
		.out_valid (v_cd),
		.side_out  (side_cd),
		.cos_raw   (cos_raw),
		.sin_raw   (sin_raw)
	);

	trz_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_cd),
		.side_in   (side_cd),
		.cos_raw   (cos_raw),
		.sin_raw   (sin_raw),
		.out_valid (done),
		.local_x   (local_x),
		.local_y   (local_y),
		.local_z   (local_z),
		.saturated (saturated)
	);

	// Every done strobe traces back to an accepted request
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, Latency))
		else $error("done without matching request");

endmodule
